// ===== rtl/core/rolrv_pkg.sv =====
// Package for the rolling least-squares residual volatility core.
// Holds the ring depth, field widths and the sequencer state type.
// No dependencies.
package rolrv_pkg;

    localparam int WINDOW_MAX  = 128;
    localparam int ADDR_W      = 7;
    localparam int SPAN_W      = 8;
    localparam int MIN_PAIRS   = 5;
    localparam int WLEN_RESET  = 20;
    localparam int ENTRY_W     = 65;
    localparam int SUM_W       = 39;
    localparam int ACC_W       = 72;
    localparam int DNUM_W      = 126;
    localparam int DREM_W      = 64;
    localparam int MEAN_STEPS  = 39;
    localparam int TDIV_STEPS  = 126;
    localparam int SDIV_STEPS  = 72;
    localparam int SQRT_STEPS  = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_P1,
        S_MEAN_X,
        S_MEAN_Y,
        S_P2,
        S_NORM,
        S_SQ,
        S_TDIV,
        S_SSR,
        S_SDIV,
        S_SQRT,
        S_FIN
    } t_state;

endpackage

// ===== rtl/core/rolling_ols_residual_volatility_core.sv =====
// A result takes a first pass over span = min(items seen, window length) entries; when the
// window is filled and at least 5 pairs are valid, the shared divider forms two means, then a
// second pass, a normalize shift s (0..9), the slope (126 steps) and SSR divisions and a square
// root follow; no root when the quotient saturates. A new beat is taken only while idle,
// once the last result is loaded; the ring passes and one-bit-per-cycle divider pace it.
// Reset (synchronous, active low): ring pointer, fill count clear, window length 20, output empty.
module rolling_ols_residual_volatility_core
    import rolrv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration channel: window length
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_stock_return,
    input  logic        i_stock_valid,
    input  logic [31:0] i_market_return,
    input  logic        i_market_valid,
    // output channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_residual_vol,
    output logic        o_vol_valid,
    output logic [7:0]  o_pair_count
);

    // ------------------------------------------------------------------
    // Ring memory: one entry per day, {pair ok, market x, stock y}.
    // One write port (on input beat), one read port with registered data.
    // Ring contents are not cleared; the window never reaches unwritten entries.
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0] mem [WINDOW_MAX];
    logic [ENTRY_W-1:0] r_rd;
    logic               r_rv;

    t_state r_state, n_state;

    logic [7:0]        r_wlen;
    logic [ADDR_W-1:0] r_wslot;
    logic [SPAN_W-1:0] r_seen;
    logic [ADDR_W-1:0] r_newest;
    logic [SPAN_W-1:0] r_span;
    logic              r_filled;
    logic [SPAN_W-1:0] r_k;
    logic [SPAN_W-1:0] r_n;

    // first pass sums
    logic signed [SUM_W-1:0] r_sx, r_sy;
    logic signed [31:0]      r_mx, r_my;

    // second pass pipeline
    logic        r_v2, r_v3;
    logic [32:0] r_adx, r_ady;
    logic        r_neg2, r_neg3;
    logic [65:0] r_pxx, r_pyy, r_pxy;
    logic [ACC_W-1:0]      r_cxx, r_cyy;
    logic signed [ACC_W:0] r_cxy;

    // normalize and square
    logic [ACC_W-1:0] r_a, r_b;
    logic [3:0]       r_s;
    logic [1:0]       r_idx;
    logic [63:0]      r_prod;
    logic [DNUM_W-1:0] r_acc;

    // shared restoring divider
    logic [DNUM_W-1:0] r_dnum;
    logic [DREM_W-1:0] r_drem, r_dden;
    logic [6:0]        r_dcnt;

    // square root
    logic [63:0] r_sv, r_sres, r_sbit;
    logic [5:0]  r_scnt;

    logic        r_res_ok;
    logic [31:0] r_vol;

    // output register
    logic        r_o_valid;
    logic [31:0] r_o_vol;
    logic        r_o_vv;
    logic [7:0]  r_o_cnt;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic              in_acc, out_acc, out_free;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        len;
    logic [SPAN_W-1:0] seen_nx;
    logic              pass_issue_done;
    logic              stats_ok;

    assign in_acc   = i_valid & o_ready;
    assign out_acc  = r_o_valid & i_ready;
    assign out_free = ~r_o_valid | i_ready;

    // window length 0 acts as 1, above the ring depth clamps
    always_comb begin
        if (r_wlen == 8'd0) begin
            len = 8'd1;
        end else if (r_wlen > 8'(WINDOW_MAX)) begin
            len = 8'(WINDOW_MAX);
        end else begin
            len = r_wlen;
        end
    end

    assign seen_nx         = (r_seen < SPAN_W'(WINDOW_MAX)) ? r_seen + 1'b1 : r_seen;
    assign pass_issue_done = (r_k == r_span);
    assign stats_ok        = r_filled && (r_n >= SPAN_W'(MIN_PAIRS));
    assign rd_addr         = r_newest - r_k[ADDR_W-1:0];

    // divider step: shift in one dividend bit, subtract when it fits
    logic [DREM_W-1:0] d_sh, d_rem_nx;
    logic              d_ge;
    assign d_sh     = {r_drem[DREM_W-2:0], r_dnum[DNUM_W-1]};
    assign d_ge     = (d_sh >= r_dden);
    assign d_rem_nx = d_ge ? d_sh - r_dden : d_sh;

    // mean magnitudes and signed results
    logic [SUM_W-1:0] sx_mag, sy_mag;
    logic [31:0]      q_mean;
    assign sx_mag = r_sx[SUM_W-1] ? SUM_W'(-r_sx) : SUM_W'(r_sx);
    assign sy_mag = r_sy[SUM_W-1] ? SUM_W'(-r_sy) : SUM_W'(r_sy);
    assign q_mean = r_dnum[31:0];

    // deviations of the returned entry
    logic signed [32:0] dx, dy;
    assign dx = $signed({r_rd[63], r_rd[63:32]}) - $signed({r_mx[31], r_mx});
    assign dy = $signed({r_rd[31], r_rd[31:0]}) - $signed({r_my[31], r_my});

    // square of the normalized cross term, 32x31 partial products
    logic [31:0] sq_lo;
    logic [30:0] sq_hi;
    logic [63:0] sq_prod;
    assign sq_lo = r_a[31:0];
    assign sq_hi = r_a[62:32];
    always_comb begin
        case (r_idx)
            2'd0:    sq_prod = 64'(sq_lo) * 64'(sq_lo);
            2'd1:    sq_prod = 64'(sq_lo) * 64'(sq_hi);
            2'd2:    sq_prod = 64'(sq_hi) * 64'(sq_hi);
            default: sq_prod = 64'd0;
        endcase
    end

    // residual sum: Cyy - (T << s), zero when T << s exceeds Cyy
    logic [ACC_W-1:0] cyy_sh, t_sh, ssr;
    logic             t_fits;
    assign cyy_sh = r_cyy >> r_s;
    assign t_fits = (r_dnum[DNUM_W-1:ACC_W] == '0) && (r_dnum[ACC_W-1:0] <= cyy_sh);
    assign t_sh   = r_dnum[ACC_W-1:0] << r_s;
    assign ssr    = t_fits ? r_cyy - t_sh : '0;

    // square root step
    logic [63:0] sq_try;
    logic        sq_ge;
    assign sq_try = r_sres + r_sbit;
    assign sq_ge  = (r_sv >= sq_try);

    logic norm_big;
    assign norm_big = (r_a[ACC_W-1:63] != '0) || (r_b[ACC_W-1:63] != '0);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_acc) n_state = S_P1;
            S_P1: begin
                if (pass_issue_done && !r_rv) begin
                    n_state = stats_ok ? S_MEAN_X : S_FIN;
                end
            end
            S_MEAN_X: if (r_dcnt == '0) n_state = S_MEAN_Y;
            S_MEAN_Y: if (r_dcnt == '0) n_state = S_P2;
            S_P2: begin
                if (pass_issue_done && !r_rv && !r_v2 && !r_v3) n_state = S_NORM;
            end
            S_NORM:   if (!norm_big) n_state = S_SQ;
            S_SQ:     if (r_idx == 2'd3) n_state = S_TDIV;
            S_TDIV:   if (r_dcnt == '0) n_state = S_SSR;
            S_SSR:    n_state = S_SDIV;
            S_SDIV: begin
                if (r_dcnt == '0) n_state = (r_dnum[71:64] != '0) ? S_FIN : S_SQRT;
            end
            S_SQRT:   if (r_scnt == '0) n_state = S_FIN;
            S_FIN:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_ready     = (r_state == S_IDLE);
        o_cfg_ready = 1'b1;
        rd_en       = ((r_state == S_P1) || (r_state == S_P2)) && !pass_issue_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Ring memory port
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            mem[r_wslot] <= {i_stock_valid & i_market_valid, i_market_return, i_stock_return};
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen    <= 8'(WLEN_RESET);
            r_wslot   <= '0;
            r_seen    <= '0;
            r_rv      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_wlen <= i_cfg_data;
            end
            if (in_acc) begin
                r_wslot <= r_wslot + 1'b1;
                r_seen  <= seen_nx;
            end
            r_rv <= rd_en;
            r_v2 <= (r_state == S_P2) && r_rv && r_rd[64];
            r_v3 <= r_v2;
            // hold the result until taken, load it when the sequencer finishes
            if ((r_state == S_FIN) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (out_acc) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        // second pass pipeline runs freely; gated by the valid flags
        r_adx  <= dx[32] ? 33'(-dx) : 33'(dx);
        r_ady  <= dy[32] ? 33'(-dy) : 33'(dy);
        r_neg2 <= dx[32] ^ dy[32];
        r_pxx  <= 66'(r_adx) * 66'(r_adx);
        r_pyy  <= 66'(r_ady) * 66'(r_ady);
        r_pxy  <= 66'(r_adx) * 66'(r_ady);
        r_neg3 <= r_neg2;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_newest <= r_wslot;
                    r_span   <= (seen_nx < len) ? seen_nx : len;
                    r_filled <= (seen_nx >= len);
                    r_k      <= '0;
                    r_n      <= '0;
                    r_sx     <= '0;
                    r_sy     <= '0;
                    r_res_ok <= 1'b0;
                    r_vol    <= '0;
                end
            end
            S_P1: begin
                if (rd_en) r_k <= r_k + 1'b1;
                if (r_rv && r_rd[64]) begin
                    r_sx <= r_sx + SUM_W'($signed(r_rd[63:32]));
                    r_sy <= r_sy + SUM_W'($signed(r_rd[31:0]));
                    r_n  <= r_n + 1'b1;
                end
                if (pass_issue_done && !r_rv) begin
                    r_dnum <= {sx_mag, (DNUM_W-SUM_W)'(0)};
                    r_drem <= '0;
                    r_dden <= DREM_W'(r_n);
                    r_dcnt <= 7'(MEAN_STEPS);
                end
            end
            S_MEAN_X: begin
                if (r_dcnt != '0) begin
                    r_dnum <= {r_dnum[DNUM_W-2:0], d_ge};
                    r_drem <= d_rem_nx;
                    r_dcnt <= r_dcnt - 1'b1;
                end else begin
                    r_mx   <= r_sx[SUM_W-1] ? -$signed(q_mean) : $signed(q_mean);
                    r_dnum <= {sy_mag, (DNUM_W-SUM_W)'(0)};
                    r_drem <= '0;
                    r_dcnt <= 7'(MEAN_STEPS);
                end
            end
            S_MEAN_Y: begin
                if (r_dcnt != '0) begin
                    r_dnum <= {r_dnum[DNUM_W-2:0], d_ge};
                    r_drem <= d_rem_nx;
                    r_dcnt <= r_dcnt - 1'b1;
                end else begin
                    r_my  <= r_sy[SUM_W-1] ? -$signed(q_mean) : $signed(q_mean);
                    r_k   <= '0;
                    r_cxx <= '0;
                    r_cyy <= '0;
                    r_cxy <= '0;
                end
            end
            S_P2: begin
                if (rd_en) r_k <= r_k + 1'b1;
                if (r_v3) begin
                    r_cxx <= r_cxx + ACC_W'(r_pxx);
                    r_cyy <= r_cyy + ACC_W'(r_pyy);
                    r_cxy <= r_neg3 ? r_cxy - $signed({7'd0, r_pxy})
                                    : r_cxy + $signed({7'd0, r_pxy});
                end
                if (pass_issue_done && !r_rv && !r_v2 && !r_v3) begin
                    r_a <= r_cxy[ACC_W] ? ACC_W'(-r_cxy) : ACC_W'(r_cxy);
                    r_b <= r_cxx;
                    r_s <= '0;
                end
            end
            S_NORM: begin
                // shift both terms until they fit 63 bits
                if (norm_big) begin
                    r_a <= r_a >> 1;
                    r_b <= r_b >> 1;
                    r_s <= r_s + 1'b1;
                end else begin
                    r_idx <= '0;
                    r_acc <= '0;
                end
            end
            S_SQ: begin
                r_prod <= sq_prod;
                r_idx  <= r_idx + 1'b1;
                case (r_idx)
                    2'd1:    r_acc <= r_acc + DNUM_W'(r_prod);
                    2'd2:    r_acc <= r_acc + (DNUM_W'(r_prod) << 33);
                    2'd3:    r_acc <= r_acc + (DNUM_W'(r_prod) << 64);
                    default: r_acc <= r_acc;
                endcase
                if (r_idx == 2'd3) begin
                    r_dnum <= (r_b[62:0] == '0) ? '0
                                                : r_acc + (DNUM_W'(r_prod) << 64);
                    r_drem <= '0;
                    r_dden <= {1'b0, r_b[62:0]};
                    r_dcnt <= (r_b[62:0] == '0) ? 7'd0 : 7'(TDIV_STEPS);
                end
            end
            S_TDIV: begin
                if (r_dcnt != '0) begin
                    r_dnum <= {r_dnum[DNUM_W-2:0], d_ge};
                    r_drem <= d_rem_nx;
                    r_dcnt <= r_dcnt - 1'b1;
                end
            end
            S_SSR: begin
                r_dnum <= {ssr, (DNUM_W-ACC_W)'(0)};
                r_drem <= '0;
                r_dden <= DREM_W'(r_n - 8'd2);
                r_dcnt <= 7'(SDIV_STEPS);
            end
            S_SDIV: begin
                if (r_dcnt != '0) begin
                    r_dnum <= {r_dnum[DNUM_W-2:0], d_ge};
                    r_drem <= d_rem_nx;
                    r_dcnt <= r_dcnt - 1'b1;
                end else if (r_dnum[71:64] != '0) begin
                    // quotient beyond 64 bits: saturate
                    r_vol    <= '1;
                    r_res_ok <= 1'b1;
                end else begin
                    r_sv   <= r_dnum[63:0];
                    r_sres <= '0;
                    r_sbit <= 64'd1 << 62;
                    r_scnt <= 6'(SQRT_STEPS);
                end
            end
            S_SQRT: begin
                if (r_scnt != '0) begin
                    if (sq_ge) begin
                        r_sv   <= r_sv - sq_try;
                        r_sres <= (r_sres >> 1) + r_sbit;
                    end else begin
                        r_sres <= r_sres >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                    r_scnt <= r_scnt - 1'b1;
                end else begin
                    r_vol    <= r_sres[31:0];
                    r_res_ok <= 1'b1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    r_o_vol <= r_vol;
                    r_o_vv  <= r_res_ok;
                    r_o_cnt <= r_n;
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    assign o_valid        = r_o_valid;
    assign o_residual_vol = r_o_vol;
    assign o_vol_valid    = r_o_vv;
    assign o_pair_count   = r_o_cnt;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_valid_needs_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_vol_valid) |-> (o_pair_count >= 8'(MIN_PAIRS)))
        else $error("valid result with too few pairs");

    a_count_le_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_P1) |-> (r_n <= r_k))
        else $error("pair count ahead of issued reads");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_TDIV) && (r_dden != '0)) |-> (r_drem < r_dden))
        else $error("divider remainder out of bound");

    a_span_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_P1) |-> ((r_span != '0) && (r_span <= SPAN_W'(WINDOW_MAX))))
        else $error("window span out of range");

endmodule

// ===== verif/rolling_ols_residual_volatility_core_tb.sv =====
// Testbench for rolling_ols_residual_volatility_core: a queue-fed driver, a monitor and
// a predictor of the rolling least-squares residual volatility that checks every beat.
// Depends on rolrv_pkg and the core RTL.
module rolling_ols_residual_volatility_core_tb
    import rolrv_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [31:0] stock;
        logic        stock_ok;
        logic [31:0] market;
        logic        market_ok;
    } t_day;

    typedef struct packed {
        logic [31:0] vol;
        logic        vol_ok;
        logic [7:0]  pairs;
    } t_vol;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_stock_return = '0;
    logic        i_stock_valid = 1'b0;
    logic [31:0] i_market_return = '0;
    logic        i_market_valid = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_residual_vol;
    logic        o_vol_valid;
    logic [7:0]  o_pair_count;

    rolling_ols_residual_volatility_core dut (.*);

    // Predictor state: its own copy of the ring, pointer, fill count and window length.
    logic signed [31:0] y_hist [WINDOW_MAX];
    logic signed [31:0] x_hist [WINDOW_MAX];
    logic               pair_hist [WINDOW_MAX];
    int unsigned        next_slot = 0;
    int unsigned        days_seen = 0;
    logic [7:0]         win_reg = 8'(WLEN_RESET);

    t_day  pending_days [$];
    t_vol  expected_vols [$];
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    int    failures = 0;
    int    cycles = 0;

    function automatic logic [31:0] isqrt64(logic [63:0] v);
        logic [63:0] root, bit_w;
        root = '0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= root + bit_w) begin
                v -= root + bit_w;
                root = (root >> 1) + bit_w;
            end else begin
                root >>= 1;
            end
            bit_w >>= 2;
        end
        return root[31:0];
    endfunction

    // Store the day, then regress over the last min(days seen, window) days.
    function automatic t_vol regress_day(t_day d);
        t_vol r;
        int unsigned wlen, span, slot, newest, n;
        logic signed [63:0] sx, sy, mx, my, dx, dy;
        logic [127:0] cxx, cyy, cxy, term, ssr;
        logic signed [127:0] cxy_s;
        int s;
        wlen = (win_reg == 0) ? 1 : win_reg;
        if (wlen > WINDOW_MAX) wlen = WINDOW_MAX;
        newest = next_slot;
        y_hist[newest] = d.stock;
        x_hist[newest] = d.market;
        pair_hist[newest] = d.stock_ok && d.market_ok;
        next_slot = (newest + 1) % WINDOW_MAX;
        if (days_seen < WINDOW_MAX) days_seen++;
        span = (days_seen < wlen) ? days_seen : wlen;
        sx = 0; sy = 0; n = 0;
        for (int k = 0; k < span; k++) begin
            slot = (newest + WINDOW_MAX - k) % WINDOW_MAX;
            if (pair_hist[slot]) begin
                sx += x_hist[slot];
                sy += y_hist[slot];
                n++;
            end
        end
        r.pairs = n[7:0];
        r.vol_ok = (days_seen >= wlen) && (n >= MIN_PAIRS);
        r.vol = '0;
        if (r.vol_ok) begin
            mx = sx / $signed(64'(n));
            my = sy / $signed(64'(n));
            cxx = '0; cyy = '0; cxy_s = '0;
            for (int k = 0; k < span; k++) begin
                slot = (newest + WINDOW_MAX - k) % WINDOW_MAX;
                if (pair_hist[slot]) begin
                    dx = x_hist[slot] - mx;
                    dy = y_hist[slot] - my;
                    cxx += 128'($signed(128'(dx)) * $signed(128'(dx)));
                    cyy += 128'($signed(128'(dy)) * $signed(128'(dy)));
                    cxy_s += $signed(128'(dx)) * $signed(128'(dy));
                end
            end
            cxy = cxy_s[127] ? 128'(-cxy_s) : 128'(cxy_s);
            s = 0;
            while (cxx[127:63] != 0 || cxy[127:63] != 0) begin
                cxx >>= 1;
                cxy >>= 1;
                s++;
            end
            term = (cxx == 0) ? '0 : (cxy * cxy) / cxx;
            // Slope term that overflows when scaled back: treat SSR as zero.
            if (s > 0 && (term >> (128 - s)) != 0) begin
                ssr = '0;
            end else begin
                term <<= s;
                ssr = (cyy >= term) ? cyy - term : '0;
            end
            ssr = ssr / (n - 2);
            r.vol = (ssr[127:64] != 0) ? 32'hFFFF_FFFF : isqrt64(ssr[63:0]);
        end
        return r;
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycles <= cycles + 1;

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Driver: advance to the next pending day once the current beat is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (pending_days.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                t_day d;
                d = pending_days.pop_front();
                i_valid         <= 1'b1;
                i_stock_return  <= d.stock;
                i_stock_valid   <= d.stock_ok;
                i_market_return <= d.market;
                i_market_valid  <= d.market_ok;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Predict on every accepted input beat, so the expectation follows the true order.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            expected_vols.insert(expected_vols.size(),
                                 regress_day({i_stock_return, i_stock_valid,
                                              i_market_return, i_market_valid}));
        if (i_rst_n && i_cfg_valid && o_cfg_ready) win_reg <= i_cfg_data;
    end

    // Monitor: random back-pressure, compare each result beat with the oldest expectation.
    always @(posedge i_clk) begin
        i_ready <= i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_vols.size() == 0) begin
                $error("unexpected result beat: vol=%h", o_residual_vol);
                failures++;
            end else begin
                t_vol e;
                e = expected_vols.pop_front();
                if (o_residual_vol !== e.vol) begin
                    $error("residual_vol: expected %h actual %h", e.vol, o_residual_vol);
                    failures++;
                end
                if (o_vol_valid !== e.vol_ok) begin
                    $error("vol_valid: expected %b actual %b", e.vol_ok, o_vol_valid);
                    failures++;
                end
                if (o_pair_count !== e.pairs) begin
                    $error("pair_count: expected %0d actual %0d", e.pairs, o_pair_count);
                    failures++;
                end
            end
        end
    end

    // Check at the falling edge so every update of the rising edge has settled,
    // then return on a rising edge.
    task automatic drain();
        do @(negedge i_clk);
        while (pending_days.size() > 0 || i_valid || expected_vols.size() > 0);
        @(posedge i_clk);
    endtask

    // Write the window length only while the core is idle.
    task automatic set_window(logic [7:0] len);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_day(logic [31:0] y, logic yv, logic [31:0] x, logic xv);
        pending_days.insert(pending_days.size(), {y, yv, x, xv});
    endtask

    // Mostly well-formed days from a noisy linear relation, some full-range noise,
    // some missing flags and the odd run of a flat market.
    task automatic push_random_days(int count);
        int kind;
        logic signed [31:0] x, y, beta, flat_x;
        beta = $signed($urandom_range(0, 8)) - 4;
        flat_x = $urandom;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 99);
            x = $signed(32'($urandom_range(0, 32'h0400_0000))) - 32'sh0200_0000;
            y = beta * (x >>> 2) + $signed(32'($urandom_range(0, 32'h0010_0000)))
                - 32'sh0008_0000;
            if (kind < 65)
                push_day(y, 1'b1, x, 1'b1);
            else if (kind < 75)
                push_day(y, 1'b1, flat_x, 1'b1);
            else if (kind < 90)
                push_day($urandom, 1'b1, $urandom, 1'b1);
            else
                push_day($urandom, 1'($urandom_range(0, 1)),
                         $urandom, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_phase(logic [7:0] len, int idle, int stall, int count);
        set_window(len);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        push_random_days(count);
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset window of 20, partial window reporting, then extremes.
        for (int i = 0; i < 3; i++) push_day(32'h0100_0000 * i, 1'b1, 32'h0080_0000, 1'b1);
        drain();
        set_window(8'd5);
        // Flat market: beta forced to zero.
        for (int i = 0; i < 5; i++) push_day(32'h0010_0000 * i, 1'b1, 32'h1234_5678, 1'b1);
        // Field extremes, driving SSR toward its largest value.
        push_day(32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 1'b1);
        push_day(32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b1);
        push_day(32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 1'b1);
        push_day(32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1);
        push_day(32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1);
        push_day(32'h8000_0000, 1'b1, 32'h0000_0000, 1'b1);
        // Missing flags drop the pair count below five.
        push_day(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b1);
        push_day(32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0);
        push_day(32'h0000_0001, 1'b0, 32'h0000_0001, 1'b0);
        // Perfect fit: residuals vanish.
        for (int i = 0; i < 6; i++) push_day(32'h0020_0000 * i, 1'b1, 32'h0010_0000 * i, 1'b1);
        drain();

        run_phase(8'd20, 0, 0, 100);
        run_phase(8'd0, 51, 0, 60);      // zero acts as one: never valid
        run_phase(8'd5, 0, 51, 120);
        run_phase(8'd128, 0, 0, 140);
        run_phase(8'd255, 19, 19, 40);   // clamps to the full ring
        run_phase(8'd1, 0, 0, 40);
        run_phase(8'd8, 19, 19, 120);
        // Pause once with the core empty, then resume in the same setting.
        push_random_days(60);
        drain();
        run_phase(8'd6, 51, 51, 60);
        run_phase(8'd12, 0, 0, 100);

        drain();
        repeat (600) @(posedge i_clk);
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
